[src/edge_interval_meter_with_average_core_assert.svh]
// Assertion macros for the edge interval meter.
// Included by eim_ctrl, which checks its own control logic.
`ifndef EDGE_INTERVAL_METER_WITH_AVERAGE_CORE_ASSERT_SVH
`define EDGE_INTERVAL_METER_WITH_AVERAGE_CORE_ASSERT_SVH

// Consequence holds in the same cycle as the antecedent.
`define EIM_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("eim: same-cycle check failed");

// Consequence holds in the cycle after the antecedent.
`define EIM_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("eim: next-cycle check failed");

`endif

[src/eim_pkg.sv]
// Shared types and constants of the edge interval meter.
// Used by the controller, the datapath and the top level.
`default_nettype none
package eim_pkg;

    localparam int IN_TDATA_W  = 8;
    localparam int OUT_TDATA_W = 112;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 11;
    localparam int IVAL_W      = 32;
    localparam int AVG_W       = 40;
    localparam int DELTA_W     = 33;

    localparam logic [CFG_IDX_W-1:0] REG_EDGE_MODE    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_AVG_WINDOW   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DELTA_ENABLE = 2'd2;

    localparam logic [1:0] EDGE_RISING  = 2'd1;
    localparam logic [1:0] EDGE_FALLING = 2'd2;

    localparam logic [CFG_DATA_W-1:0] AVG_WINDOW_RESET = 11'd100;

    typedef enum logic [2:0] {
        S_IDLE,
        S_UPD,
        S_DSTART,
        S_DIV,
        S_LOAD
    } t_state;

    typedef struct packed {
        logic ready;
        logic accept;
        logic upd;
        logic dstart;
        logic dstep;
        logic load;
    } t_cmd;

    typedef struct packed {
        logic result;
        logic win_on;
        logic div_done;
        logic out_free;
    } t_status;

endpackage
`default_nettype wire

[src/eim_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none
module eim_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_we,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]                      i_wdata,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic      [WIDTH-1:0]                      o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

[src/eim_ctrl.sv]
// Controller of the edge interval meter: sequences the ring update,
// the average division and the result load. Uses eim_pkg and the assert header.
`default_nettype none
`include "edge_interval_meter_with_average_core_assert.svh"
module eim_ctrl (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_s_tvalid,
    input  wire eim_pkg::t_status i_status,
    output eim_pkg::t_cmd         o_cmd
);
    import eim_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                o_cmd.ready  = 1'b1;
                o_cmd.accept = i_s_tvalid;
                if (i_s_tvalid && i_status.result) begin
                    n_state = i_status.win_on ? S_UPD : S_LOAD;
                end
            end
            S_UPD: begin
                o_cmd.upd = 1'b1;
                n_state   = S_DSTART;
            end
            S_DSTART: begin
                o_cmd.dstart = 1'b1;
                n_state      = S_DIV;
            end
            S_DIV: begin
                if (i_status.div_done) begin
                    n_state = S_LOAD;
                end else begin
                    o_cmd.dstep = 1'b1;
                end
            end
            S_LOAD: begin
                if (i_status.out_free) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    `EIM_ASSERT_SAME(a_accept_idle, i_clk, i_rst_n, o_cmd.accept, r_state == S_IDLE)
    `EIM_ASSERT_NEXT(a_upd_then_start, i_clk, i_rst_n, r_state == S_UPD, r_state == S_DSTART)
    `EIM_ASSERT_NEXT(a_load_then_idle, i_clk, i_rst_n, o_cmd.load, r_state == S_IDLE)
    `EIM_ASSERT_SAME(a_step_not_done, i_clk, i_rst_n, o_cmd.dstep, !i_status.div_done)
endmodule
`default_nettype wire

[src/eim_dp.sv]
// Datapath of the edge interval meter: edge detect, interval counter,
// interval ring with running sum, bit-serial divider and output register.
// Uses eim_pkg and eim_ram.
`default_nettype none
module eim_dp #(
    parameter int WINDOW_MAX = 1024,
    parameter int COUNT_BITS = 32
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic [eim_pkg::IN_TDATA_W-1:0]  i_s_tdata,
    output logic                                 o_m_tvalid,
    input  wire logic                            i_m_tready,
    output logic      [eim_pkg::OUT_TDATA_W-1:0] o_m_tdata,
    input  wire logic                            i_cfg_wr_en,
    input  wire logic [eim_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  wire logic [eim_pkg::CFG_DATA_W-1:0]  i_cfg_wdata,
    input  wire eim_pkg::t_cmd                   i_cmd,
    output eim_pkg::t_status                     o_status
);
    import eim_pkg::*;

    localparam int HEAD_W = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
    localparam int FILL_W = $clog2(WINDOW_MAX + 1);
    localparam int SUM_W  = IVAL_W + FILL_W;
    localparam int DIV_W  = SUM_W + 8;
    localparam int DCNT_W = $clog2(DIV_W + 1);
    localparam int WCMP_W = (FILL_W > CFG_DATA_W) ? FILL_W : CFG_DATA_W;
    localparam int CWIDE  = (COUNT_BITS > IVAL_W) ? COUNT_BITS : IVAL_W;

    // Configuration registers.
    logic [1:0]            r_edge_mode;
    logic [CFG_DATA_W-1:0] r_avg_window;
    logic                  r_delta_en;

    // Edge and interval state.
    logic                  r_prev_level;
    logic                  r_have_prev;
    logic                  r_have_start;
    logic [COUNT_BITS-1:0] r_cnt;
    logic [IVAL_W-1:0]     r_last;
    logic                  r_have_last;

    // Ring state.
    logic [HEAD_W-1:0]     r_head;
    logic [FILL_W-1:0]     r_fill;
    logic [SUM_W-1:0]      r_sum;

    // Pending result.
    logic [IVAL_W-1:0]     r_ival;
    logic [DELTA_W-1:0]    r_delta;
    logic                  r_delta_ok;
    logic                  r_avg_ok;

    // Divider.
    logic [FILL_W-1:0]     r_rem;
    logic [DIV_W-1:0]      r_quo;
    logic [DCNT_W-1:0]     r_dcnt;

    logic                  r_m_tvalid;
    logic [OUT_TDATA_W-1:0] r_m_tdata;

    logic                  lvl;
    logic                  edge_hit;
    logic [COUNT_BITS-1:0] n_cnt;
    logic [CWIDE-1:0]      cnt_wide;
    logic [IVAL_W-1:0]     ival;
    logic [FILL_W-1:0]     win;
    logic                  full;
    logic [IVAL_W-1:0]     ram_rdata;
    logic [FILL_W:0]       trial;
    logic [FILL_W:0]       trial_sub;
    logic [AVG_W-1:0]      avg;

    assign lvl = i_s_tdata[0];

    always_comb begin
        edge_hit = 1'b0;
        if (r_have_prev && (lvl != r_prev_level)) begin
            if (r_edge_mode == EDGE_RISING) begin
                edge_hit = lvl;
            end else if (r_edge_mode == EDGE_FALLING) begin
                edge_hit = !lvl;
            end else begin
                edge_hit = 1'b1;
            end
        end
    end

    assign n_cnt    = (r_have_start && (r_cnt != '1)) ? r_cnt + 1'b1 : r_cnt;
    assign cnt_wide = CWIDE'(n_cnt);
    assign ival     = (cnt_wide > CWIDE'(32'hFFFF_FFFF)) ? '1 : cnt_wide[IVAL_W-1:0];

    assign win  = (WCMP_W'(r_avg_window) > WCMP_W'(WINDOW_MAX)) ?
                  FILL_W'(WINDOW_MAX) : FILL_W'(r_avg_window);
    assign full = (r_fill >= win);

    assign o_status.result   = edge_hit && r_have_start;
    assign o_status.win_on   = (win != '0);
    assign o_status.div_done = (r_dcnt == DCNT_W'(DIV_W));
    assign o_status.out_free = !r_m_tvalid || i_m_tready;

    eim_ram #(
        .WIDTH (IVAL_W),
        .DEPTH (WINDOW_MAX)
    ) u_ring (
        .i_clk   (i_clk),
        .i_we    (i_cmd.upd),
        .i_waddr (r_head),
        .i_wdata (r_ival),
        .i_raddr (r_head),
        .o_rdata (ram_rdata)
    );

    // Restoring division, one quotient bit per cycle.
    assign trial     = {r_rem, r_quo[DIV_W-1]};
    assign trial_sub = trial - {1'b0, r_fill};

    assign avg = r_avg_ok ? r_quo[AVG_W-1:0] : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_edge_mode  <= '0;
            r_avg_window <= AVG_WINDOW_RESET;
            r_delta_en   <= 1'b0;
            r_prev_level <= 1'b0;
            r_have_prev  <= 1'b0;
            r_have_start <= 1'b0;
            r_cnt        <= '0;
            r_last       <= '0;
            r_have_last  <= 1'b0;
            r_head       <= '0;
            r_fill       <= '0;
            r_sum        <= '0;
            r_dcnt       <= '0;
            r_m_tvalid   <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                case (i_cfg_index)
                    REG_EDGE_MODE:    r_edge_mode <= i_cfg_wdata[1:0];
                    REG_AVG_WINDOW: begin
                        r_avg_window <= i_cfg_wdata;
                        r_head       <= '0;
                        r_fill       <= '0;
                        r_sum        <= '0;
                    end
                    REG_DELTA_ENABLE: r_delta_en  <= i_cfg_wdata[0];
                    default: ;
                endcase
            end

            if (i_cmd.accept) begin
                r_prev_level <= lvl;
                r_have_prev  <= 1'b1;
                if (edge_hit) begin
                    r_cnt        <= '0;
                    r_have_start <= 1'b1;
                    if (r_have_start) begin
                        r_last      <= ival;
                        r_have_last <= 1'b1;
                    end
                end else begin
                    r_cnt <= n_cnt;
                end
            end

            if (i_cmd.upd) begin
                if (full) begin
                    r_sum <= r_sum - SUM_W'(ram_rdata) + SUM_W'(r_ival);
                end else begin
                    r_sum  <= r_sum + SUM_W'(r_ival);
                    r_fill <= r_fill + 1'b1;
                end
                if ((FILL_W'(r_head) + 1'b1) >= win) begin
                    r_head <= '0;
                end else begin
                    r_head <= r_head + 1'b1;
                end
            end

            if (i_cmd.dstart) begin
                r_dcnt <= '0;
            end else if (i_cmd.dstep) begin
                r_dcnt <= r_dcnt + 1'b1;
            end

            if (i_cmd.load) begin
                r_m_tvalid <= 1'b1;
            end else if (i_m_tready) begin
                r_m_tvalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept && edge_hit && r_have_start) begin
            r_ival     <= ival;
            r_delta    <= {1'b0, ival} - {1'b0, r_last};
            r_delta_ok <= r_delta_en && r_have_last;
            r_avg_ok   <= (win != '0);
        end
        if (i_cmd.dstart) begin
            r_rem <= '0;
            r_quo <= {r_sum, 8'd0};
        end else if (i_cmd.dstep) begin
            if (!trial_sub[FILL_W]) begin
                r_rem <= trial_sub[FILL_W-1:0];
                r_quo <= {r_quo[DIV_W-2:0], 1'b1};
            end else begin
                r_rem <= trial[FILL_W-1:0];
                r_quo <= {r_quo[DIV_W-2:0], 1'b0};
            end
        end
        if (i_cmd.load) begin
            r_m_tdata <= {5'd0, r_delta_ok, (r_delta_ok ? r_delta : DELTA_W'(0)),
                          r_avg_ok, avg, r_ival};
        end
    end

    assign o_m_tvalid = r_m_tvalid;
    assign o_m_tdata  = r_m_tdata;
endmodule
`default_nettype wire

[src/edge_interval_meter_with_average_core.sv]
// Edge interval meter: takes one sampled level per request and, for every
// qualifying edge after the first, returns the interval since the previous
// edge, the moving average of the last avg_window intervals (8 fractional
// bits) and optionally the difference from the previous interval. A sample
// that yields no result leaves the core ready for the next. A sample that
// yields a result with averaging enabled goes through the ring update, the
// divider start, the one-bit-per-cycle divider and the result load, which
// waits for a free output register; with the average disabled it goes
// straight to the load. The output register lets the next sample be taken
// while a result waits. The interval ring memory needs no clearing pass.
`default_nettype none
module edge_interval_meter_with_average_core #(
    parameter int WINDOW_MAX = 1024,
    parameter int COUNT_BITS = 32
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_s_tvalid,
    output logic                                 o_s_tready,
    // [0] level, [7:1] zero
    input  wire logic [eim_pkg::IN_TDATA_W-1:0]  i_s_tdata,
    output logic                                 o_m_tvalid,
    input  wire logic                            i_m_tready,
    // [31:0] interval, [71:32] average, [72] average_valid,
    // [105:73] delta, [106] delta_valid, [111:107] zero
    output logic      [eim_pkg::OUT_TDATA_W-1:0] o_m_tdata,
    input  wire logic                            i_cfg_wr_en,
    input  wire logic [eim_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  wire logic [eim_pkg::CFG_DATA_W-1:0]  i_cfg_wdata
);
    import eim_pkg::*;

    t_cmd    cmd;
    t_status status;

    eim_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    eim_dp #(
        .WINDOW_MAX (WINDOW_MAX),
        .COUNT_BITS (COUNT_BITS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tdata   (i_s_tdata),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_index (i_cfg_index),
        .i_cfg_wdata (i_cfg_wdata),
        .i_cmd       (cmd),
        .o_status    (status)
    );

    assign o_s_tready = cmd.ready;
endmodule
`default_nettype wire

[sim/tb_top.sv]
// Testbench for the edge interval meter core: drives sampled levels over the
// input stream, predicts each interval/average/delta result and checks it.
// Depends on eim_pkg and edge_interval_meter_with_average_core.
`default_nettype none
module tb_top;
    import eim_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int WIN_MAX = 1024;
    localparam int CLK_HALF = 4;
    localparam logic [1:0] EDGE_ANY = 2'd0;
    localparam logic [1:0] EDGE_ALT = 2'd3;

    typedef struct packed {
        logic               delta_ok;
        logic [DELTA_W-1:0] delta;
        logic               average_ok;
        logic [AVG_W-1:0]   average;
        logic [IVAL_W-1:0]  interval;
    } t_meas;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   i_s_tvalid = 1'b0;
    logic                   o_s_tready;
    logic [IN_TDATA_W-1:0]  i_s_tdata = '0;
    logic                   o_m_tvalid;
    logic                   i_m_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] o_m_tdata;
    logic                   i_cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]   i_cfg_index = '0;
    logic [CFG_DATA_W-1:0]  i_cfg_wdata = '0;

    edge_interval_meter_with_average_core dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_s_tvalid(i_s_tvalid), .o_s_tready(o_s_tready), .i_s_tdata(i_s_tdata),
        .o_m_tvalid(o_m_tvalid), .i_m_tready(i_m_tready), .o_m_tdata(o_m_tdata),
        .i_cfg_wr_en(i_cfg_wr_en), .i_cfg_index(i_cfg_index),
        .i_cfg_wdata(i_cfg_wdata)
    );

    always #CLK_HALF i_clk = ~i_clk;

    // Predictor state.
    logic [1:0]        mode_q;
    logic [10:0]       window_q;
    logic              delta_en_q;
    logic              last_level;
    logic              level_seen;
    logic              timing;
    logic [31:0]       sample_count;
    logic [31:0]       ring [WIN_MAX];
    int unsigned       ring_head;
    int unsigned       ring_fill;
    logic [41:0]       ring_sum;
    logic [31:0]       prev_interval;
    logic              prev_interval_ok;

    t_meas       pending_meas[$];
    int          errors = 0;
    int          meas_checked = 0;
    int          samples_sent = 0;
    bit          idle_gaps = 1'b1;
    int          hold_cycles = 0;

    task automatic clear_ring();
        ring_head = 0;
        ring_fill = 0;
        ring_sum = '0;
    endtask

    task automatic predict_sample(input logic lvl);
        logic       edge_hit;
        int unsigned win;
        t_meas      m;
        logic [49:0] scaled;
        edge_hit = level_seen && (last_level != lvl) &&
            (mode_q == EDGE_RISING ? lvl : mode_q == EDGE_FALLING ? !lvl : 1'b1);
        last_level = lvl;
        level_seen = 1'b1;
        if (timing && sample_count != 32'hFFFF_FFFF)
            sample_count++;
        if (!edge_hit)
            return;
        if (!timing) begin
            timing = 1'b1;
            sample_count = '0;
            return;
        end
        m = '0;
        m.interval = sample_count;
        sample_count = '0;
        win = (window_q > WIN_MAX) ? WIN_MAX : window_q;
        if (win > 0 && ring_head < WIN_MAX) begin
            if (ring_fill >= win)
                ring_sum -= ring[ring_head];
            else
                ring_fill++;
            ring[ring_head] = m.interval;
            ring_sum += m.interval;
            ring_head++;
            if (ring_head >= win)
                ring_head = 0;
            scaled = {ring_sum, 8'd0} / ring_fill;
            m.average = scaled[AVG_W-1:0];
            m.average_ok = 1'b1;
        end
        if (delta_en_q && prev_interval_ok) begin
            m.delta = {1'b0, m.interval} - {1'b0, prev_interval};
            m.delta_ok = 1'b1;
        end
        prev_interval = m.interval;
        prev_interval_ok = 1'b1;
        pending_meas.push_back(m);
    endtask

    // The request stays valid between back-to-back samples; gaps and
    // wait_idle drop it.
    task automatic send_sample(input logic lvl);
        if (idle_gaps && $urandom_range(0, 5) == 0) begin
            i_s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(negedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata <= {{(IN_TDATA_W-1){1'b0}}, lvl};
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
        predict_sample(lvl);
        samples_sent++;
        @(negedge i_clk);
    endtask

    // Drain outstanding results, then let an edgeless sample finish.
    task automatic wait_idle();
        int guard;
        guard = 0;
        i_s_tvalid <= 1'b0;
        while (pending_meas.size() != 0 && guard < 200000) begin
            @(negedge i_clk);
            guard++;
        end
        repeat (70) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        wait_idle();
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_wdata <= val;
        @(negedge i_clk);
        i_cfg_wr_en <= 1'b0;
        case (idx)
            REG_EDGE_MODE:    mode_q = val[1:0];
            REG_AVG_WINDOW: begin
                window_q = val;
                clear_ring();
            end
            REG_DELTA_ENABLE: delta_en_q = val[0];
            default: ;
        endcase
    endtask

    // Square wave with random run lengths.
    task automatic send_runs(input int count, input int max_run);
        logic lvl;
        lvl = last_level;
        for (int k = 0; k < count; k++) begin
            if (k == 0 || $urandom_range(0, max_run) == 0)
                lvl = ~lvl;
            send_sample(lvl);
        end
    endtask

    task automatic test_directed();
        // First sample only loads the level, first edge only starts timing.
        send_sample(1'b1);
        send_sample(1'b0);
        send_sample(1'b0);
        send_sample(1'b1);
        send_sample(1'b1);
        send_sample(1'b1);
        send_sample(1'b0);
        send_sample(1'b1);
        write_reg(REG_DELTA_ENABLE, 11'd1);
        send_sample(1'b0);
        send_sample(1'b0);
        send_sample(1'b1);
        write_reg(REG_EDGE_MODE, {9'd0, EDGE_RISING});
        send_runs(8, 2);
        write_reg(REG_EDGE_MODE, {9'd0, EDGE_FALLING});
        send_runs(8, 2);
        write_reg(REG_EDGE_MODE, {9'd0, EDGE_ALT});
        // Window disabled leaves the ring untouched.
        write_reg(REG_AVG_WINDOW, 11'd0);
        send_runs(6, 1);
    endtask

    task automatic test_windows();
        // Window of one, of three, the largest field value (above the maximum) and the maximum.
        write_reg(REG_AVG_WINDOW, 11'd1);
        send_runs(30, 3);
        write_reg(REG_AVG_WINDOW, 11'd3);
        send_runs(60, 4);
        write_reg(REG_AVG_WINDOW, 11'h7FF);
        write_reg(REG_EDGE_MODE, {9'd0, EDGE_ANY});
        send_runs(60, 2);
        write_reg(REG_AVG_WINDOW, 11'd1024);
        send_runs(40, 2);
    endtask

    task automatic test_random();
        for (int phase = 0; phase < 6; phase++) begin
            write_reg(REG_EDGE_MODE, 11'($urandom_range(0, 3)));
            write_reg(REG_AVG_WINDOW,
                      ($urandom_range(0, 3) == 0) ? 11'($urandom_range(0, 2047))
                                                  : 11'($urandom_range(0, 8)));
            write_reg(REG_DELTA_ENABLE, 11'($urandom_range(0, 1)));
            send_runs(120, $urandom_range(1, 12));
        end
    endtask

    task automatic test_backpressure();
        // Receiver stalls long while samples keep coming.
        write_reg(REG_AVG_WINDOW, 11'd4);
        hold_cycles = 400;
        send_runs(60, 1);
        idle_gaps = 1'b0;
        send_runs(100, 3);
    endtask

    // Sink: random stalls, plus a long hold-off when requested.
    always @(negedge i_clk) begin
        if (hold_cycles > 0) begin
            hold_cycles <= hold_cycles - 1;
            i_m_tready <= 1'b0;
        end else if (idle_gaps) begin
            i_m_tready <= ($urandom_range(0, 4) != 0);
        end else begin
            i_m_tready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        t_meas got;
        t_meas want;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            got = o_m_tdata[$bits(t_meas)-1:0];
            if (pending_meas.size() == 0) begin
                $display("%0t: unexpected measurement %h", $realtime, got);
                errors++;
            end else begin
                want = pending_meas.pop_front();
                meas_checked++;
                if (got.interval !== want.interval)
                    $display("%0t: interval exp %0d got %0d", $realtime,
                             want.interval, got.interval);
                if (got.average !== want.average)
                    $display("%0t: average exp %h got %h", $realtime,
                             want.average, got.average);
                if (got.average_ok !== want.average_ok)
                    $display("%0t: average_valid exp %b got %b", $realtime,
                             want.average_ok, got.average_ok);
                if (got.delta !== want.delta)
                    $display("%0t: delta exp %h got %h", $realtime,
                             want.delta, got.delta);
                if (got.delta_ok !== want.delta_ok)
                    $display("%0t: delta_valid exp %b got %b", $realtime,
                             want.delta_ok, got.delta_ok);
                if (got !== want)
                    errors++;
            end
        end
    end

    initial begin
        mode_q = EDGE_ANY;
        window_q = AVG_WINDOW_RESET;
        delta_en_q = 1'b0;
        last_level = 1'b0;
        level_seen = 1'b0;
        timing = 1'b0;
        sample_count = '0;
        prev_interval = '0;
        prev_interval_ok = 1'b0;
        clear_ring();
        repeat (9) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        test_directed();
        test_windows();
        test_random();
        test_backpressure();
        wait_idle();
        if (pending_meas.size() != 0) begin
            $display("%0t: %0d measurements never arrived", $realtime,
                     pending_meas.size());
            errors++;
        end
        $display("Sent %0d samples over all edge modes and window sizes,", samples_sent);
        $display("checked %0d measurements with delta on and off.", meas_checked);
        if (errors == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    initial begin
        #20ms;
        $display("TEST FAILED");
        $finish;
    end
endmodule
`default_nettype wire

[filelist.f]
+incdir+src
src/eim_pkg.sv
src/eim_ram.sv
src/eim_ctrl.sv
src/eim_dp.sv
src/edge_interval_meter_with_average_core.sv
sim/tb_top.sv
